FILE: rtl/core/utt_pkg.sv
`timescale 1ns / 1ps

package utt_pkg;

	// request codes carried in req_type
	localparam logic [2:0] REQ_OPEN  = 3'd0;
	localparam logic [2:0] REQ_SETUP = 3'd1;
	localparam logic [2:0] REQ_START = 3'd2;
	localparam logic [2:0] REQ_DONE  = 3'd3;
	localparam logic [2:0] REQ_ERROR = 3'd4;

	// token kinds
	localparam logic [1:0] PID_OUT   = 2'd0;
	localparam logic [1:0] PID_IN    = 2'd1;
	localparam logic [1:0] PID_SETUP = 2'd2;

	// completion status
	localparam logic [1:0] ST_SUCCESS = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_FAILED  = 2'd2;

	localparam int unsigned  EP_DIR_BIT = 7;
	localparam logic [15:0]  SETUP_LEN  = 16'd8;

	typedef enum logic [1:0] {
		TOG_NONE,
		TOG_CLEAR,
		TOG_SET_EP0,
		TOG_FLIP
	} tog_op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [6:0]  usb_dev;
		logic [7:0]  ep_addr;
		logic [15:0] xfer_length;
		logic        no_reply;
		logic        crc_err;
		logic [9:0]  rx_count;
	} req_t;

	typedef struct packed {
		logic        token_valid;
		logic [1:0]  token_pid;
		logic        token_toggle;
		logic [15:0] token_length;
		logic [6:0]  report_dev;
		logic [7:0]  report_ep;
		logic        done_valid;
		logic [1:0]  done_status;
		logic [9:0]  done_length;
	} rsp_t;

	typedef struct packed {
		logic [6:0] dev;
		logic [3:0] epn;
		logic       is_in;
	} tog_addr_t;

	typedef struct packed {
		tog_op_t   op;
		tog_addr_t addr;
	} tog_cmd_t;

	typedef struct packed {
		logic       busy;
		logic [6:0] dev;
		logic [7:0] ep;
		logic       is_in;
	} pend_t;

endpackage

FILE: rtl/core/utt_toggle_store.sv
`timescale 1ns / 1ps

// Toggle bits per tracked device, endpoint and direction.
module utt_toggle_store #(
	parameter int unsigned TRACKED_DEVICES = 8,
	parameter int unsigned ENDPOINTS       = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  utt_pkg::tog_addr_t  rd,
	output logic                rd_toggle,
	input  utt_pkg::tog_cmd_t   wr
);

	localparam int unsigned DEV_W = (TRACKED_DEVICES > 1) ? $clog2(TRACKED_DEVICES) : 1;
	localparam int unsigned EP_W  = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

	logic [TRACKED_DEVICES-1:0][ENDPOINTS-1:0] in_tog_q;
	logic [TRACKED_DEVICES-1:0][ENDPOINTS-1:0] out_tog_q;

	logic             rd_trk, wr_trk;
	logic [DEV_W-1:0] rd_dev, wr_dev;
	logic [EP_W-1:0]  rd_ep, wr_ep;

	assign rd_trk = ({1'b0, rd.dev} < 8'(TRACKED_DEVICES)) && ({1'b0, rd.epn} < 5'(ENDPOINTS));
	assign wr_trk = ({1'b0, wr.addr.dev} < 8'(TRACKED_DEVICES))
		&& ({1'b0, wr.addr.epn} < 5'(ENDPOINTS));

	assign rd_dev = rd.dev[DEV_W-1:0];
	assign rd_ep  = rd.epn[EP_W-1:0];
	assign wr_dev = wr.addr.dev[DEV_W-1:0];
	assign wr_ep  = wr.addr.epn[EP_W-1:0];

	always_comb begin
		rd_toggle = 1'b0;
		if (rd_trk) begin
			rd_toggle = rd.is_in ? in_tog_q[rd_dev][rd_ep] : out_tog_q[rd_dev][rd_ep];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tog_q  <= '0;
			out_tog_q <= '0;
		end else if (wr_trk) begin
			case (wr.op)
				utt_pkg::TOG_CLEAR: begin
					if (wr.addr.is_in) in_tog_q[wr_dev][wr_ep] <= 1'b0;
					else out_tog_q[wr_dev][wr_ep] <= 1'b0;
				end
				utt_pkg::TOG_SET_EP0: begin
					in_tog_q[wr_dev][0]  <= 1'b1;
					out_tog_q[wr_dev][0] <= 1'b1;
				end
				utt_pkg::TOG_FLIP: begin
					if (wr.addr.is_in) in_tog_q[wr_dev][wr_ep] <= ~in_tog_q[wr_dev][wr_ep];
					else out_tog_q[wr_dev][wr_ep] <= ~out_tog_q[wr_dev][wr_ep];
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/utt_decode.sv
`timescale 1ns / 1ps

// Request decode: result, pending record update and toggle command.
module utt_decode (
	input  logic                fire,
	input  utt_pkg::req_t       req,
	input  utt_pkg::pend_t      pend,
	input  logic                rd_toggle,
	output utt_pkg::tog_addr_t  rd,
	output utt_pkg::tog_cmd_t   wr,
	output utt_pkg::pend_t      pend_next,
	output utt_pkg::rsp_t       rsp
);

	logic is_in;

	assign is_in = req.ep_addr[utt_pkg::EP_DIR_BIT];

	assign rd.dev   = req.usb_dev;
	assign rd.epn   = req.ep_addr[3:0];
	assign rd.is_in = is_in;

	always_comb begin
		rsp          = '0;
		pend_next    = pend;
		wr.op        = utt_pkg::TOG_NONE;
		wr.addr      = rd;
		case (req.req_type)
			utt_pkg::REQ_OPEN: begin
				wr.op = utt_pkg::TOG_CLEAR;
			end
			utt_pkg::REQ_SETUP: begin
				pend_next = '{busy: 1'b1, dev: req.usb_dev, ep: 8'd0, is_in: 1'b0};
				wr.op            = utt_pkg::TOG_SET_EP0;
				wr.addr.epn      = 4'd0;
				rsp.token_valid  = 1'b1;
				rsp.token_pid    = utt_pkg::PID_SETUP;
				rsp.token_length = utt_pkg::SETUP_LEN;
				rsp.report_dev   = req.usb_dev;
			end
			utt_pkg::REQ_START: begin
				pend_next = '{busy: 1'b1, dev: req.usb_dev, ep: req.ep_addr, is_in: is_in};
				rsp.token_valid  = 1'b1;
				rsp.token_pid    = is_in ? utt_pkg::PID_IN : utt_pkg::PID_OUT;
				rsp.token_toggle = rd_toggle;
				rsp.token_length = req.xfer_length;
				rsp.report_dev   = req.usb_dev;
				rsp.report_ep    = req.ep_addr;
			end
			utt_pkg::REQ_DONE: begin
				if (pend.busy) begin
					pend_next.busy  = 1'b0;
					wr.addr.dev     = pend.dev;
					wr.addr.epn     = pend.ep[3:0];
					wr.addr.is_in   = pend.is_in;
					rsp.report_dev  = pend.dev;
					rsp.report_ep   = pend.ep;
					rsp.done_valid  = 1'b1;
					if (req.no_reply) begin
						rsp.done_status = utt_pkg::ST_TIMEOUT;
					end else if (req.crc_err) begin
						rsp.done_status = utt_pkg::ST_FAILED;
					end else begin
						rsp.done_status = utt_pkg::ST_SUCCESS;
						rsp.done_length = req.rx_count;
						wr.op           = utt_pkg::TOG_FLIP;
					end
				end
			end
			utt_pkg::REQ_ERROR: begin
				if (pend.busy) begin
					pend_next.busy  = 1'b0;
					rsp.report_dev  = pend.dev;
					rsp.report_ep   = pend.ep;
					rsp.done_valid  = 1'b1;
					rsp.done_status = utt_pkg::ST_FAILED;
				end
			end
			default: ;
		endcase
		if (!fire) begin
			wr.op     = utt_pkg::TOG_NONE;
			pend_next = pend;
		end
	end

endmodule

FILE: rtl/core/usb_host_data_toggle_tracker.sv
`timescale 1ns / 1ps

// USB host data-toggle tracker. Each request transaction (open endpoint,
// setup, start transfer, transfer done, error event) gives exactly one
// response transaction, in order. A transaction is taken every clock cycle
// when the response side keeps up; an accepted request passes through one
// request register and then one response register, which presents the
// response and holds it while rsp_ready is low. The rate rests on the
// read-modify-write of the toggle flip-flops and the pending-transfer
// record, done between those two registers. Toggle bits reset to DATA0;
// devices at or above TRACKED_DEVICES and endpoint numbers at or above
// ENDPOINTS always see DATA0 and never change state. Only one transfer is
// pending: a new setup or start replaces it. Response fields that do not
// apply read as zero.
module usb_host_data_toggle_tracker #(
	parameter int unsigned TRACKED_DEVICES = 8,
	parameter int unsigned ENDPOINTS       = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  utt_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output utt_pkg::rsp_t  rsp_data
);

	// request register
	logic          v_s1;
	utt_pkg::req_t req_s1;

	// response register
	logic          rsp_v_q;
	utt_pkg::rsp_t rsp_q;

	// pending transfer record
	utt_pkg::pend_t pend_q, pend_next;

	utt_pkg::tog_addr_t tog_rd;
	utt_pkg::tog_cmd_t  tog_wr;
	utt_pkg::rsp_t      rsp_next;
	logic               tog_bit;
	logic               advance;
	logic               fire;

	// s1 may move on whenever the response register is empty or draining
	assign advance   = !rsp_v_q || rsp_ready;
	assign fire      = v_s1 && advance;
	assign req_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	utt_decode u_decode (
		.fire      (fire),
		.req       (req_s1),
		.pend      (pend_q),
		.rd_toggle (tog_bit),
		.rd        (tog_rd),
		.wr        (tog_wr),
		.pend_next (pend_next),
		.rsp       (rsp_next)
	);

	utt_toggle_store #(
		.TRACKED_DEVICES (TRACKED_DEVICES),
		.ENDPOINTS       (ENDPOINTS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (tog_rd),
		.rd_toggle (tog_bit),
		.wr        (tog_wr)
	);

	// pending record is control state: reset clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	// a setup or start leaves a transfer pending
	a_start_pends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req_s1.req_type == utt_pkg::REQ_SETUP || req_s1.req_type == utt_pkg::REQ_START)
		|=> pend_q.busy)
		else $error("setup/start did not leave a pending transfer");

	// a completion reported ends the pending transfer
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp_next.done_valid |=> !pend_q.busy && rsp_valid && rsp_data.done_valid)
		else $error("completion left transfer pending");

	// a completion needs a pending transfer
	a_done_needs_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp_next.done_valid |-> pend_q.busy)
		else $error("completion without pending transfer");

	// token and completion never share a response
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.token_valid && rsp_data.done_valid))
		else $error("token and completion in one response");

	// full request register with stalled response must back-pressure
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while pipeline stalled");
`endif

endmodule
